/* design/arc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_pkg
// Shared constants for the adaptive replacement cache policy block.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int NUM_SETS_DEF = 64;
  localparam int WAYS_DEF     = 8;
  localparam int TAG_BITS_DEF = 20;

  localparam logic [1:0] FN_TOUCH = 2'd0;
  localparam logic [1:0] FN_MISS  = 2'd1;
  localparam logic [1:0] FN_INVAL = 2'd2;

  localparam logic [1:0] ST_INVALID = 2'd0;
  localparam logic [1:0] ST_RECENT  = 2'd1;
  localparam logic [1:0] ST_FREQ    = 2'd2;

  localparam logic [1:0] L_T1 = 2'd0;
  localparam logic [1:0] L_T2 = 2'd1;
  localparam logic [1:0] L_B1 = 2'd2;
  localparam logic [1:0] L_B2 = 2'd3;

endpackage

/* design/arc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_div
// Small unsigned divider by repeated subtraction, one subtract per cycle.
// ----------------------------------------------------------------------------
module arc_div #(
  parameter int W = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  logic [W-1:0] rem;
  logic         run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        rem  <= num;
        quo  <= '0;
        run  <= 1'b1;
        done <= 1'b0;
      end else if (run) begin
        if (rem >= den) begin
          rem  <= rem - den;
          quo  <= quo + 1'b1;
          done <= 1'b0;
        end else begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* design/arc_cache_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_cache_replacement
// Per-set adaptive replacement cache policy with four tag lists per set.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction per operation (touch, miss fill,
// invalidate) on one set. Output channel m_*: one result transaction per
// operation: victim way, free-way and eviction flags, evicted tag, list
// placement and the set's target p.
// Each operation reads the set's whole state row from a single-port memory,
// works on it with one shared compare unit (one list entry or one way per
// cycle) and one subtract-per-cycle divider, then writes the row back.
// An ignored operation passes set index wrap, load and dispatch straight
// to write-back; touch or invalidate adds one list scan; a miss adds up to
// four list scans, one way scan and a division of list lengths. Set index
// wrap repeats a subtraction of NUM_SETS while the index is out of range.
// s_tready is high only while the block is idle; one operation at a time,
// the next one accepted the cycle after the previous result issues.
// After reset the block sweeps the state memory, one set per cycle, and
// clears every set before it takes the first transaction.
// A stalled result holds in the output register; the next operation may be
// accepted meanwhile and waits at write-back until the result is taken.
// ----------------------------------------------------------------------------
module arc_cache_replacement #(
  parameter int NUM_SETS = arc_pkg::NUM_SETS_DEF,
  parameter int WAYS     = arc_pkg::WAYS_DEF,
  parameter int TAG_BITS = arc_pkg::TAG_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // func[1:0], set_index[7:2], way[10:8], tag
  input  logic [((11+TAG_BITS+7)/8)*8-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // victim_way[2:0], used_free_way, evicted_valid, evicted_tag,
  // placed_frequent, target_p
  output logic [((10+TAG_BITS+7)/8)*8-1:0]      m_tdata
);

  import arc_pkg::*;

  localparam int OUT_W = ((10+TAG_BITS+7)/8)*8;
  localparam int WI    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LW    = $clog2(WAYS+1);
  localparam int SW    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int ROW_W = LW + 4*LW + 4*WAYS*TAG_BITS + WAYS*2 + WAYS*TAG_BITS;

  typedef logic [WAYS-1:0][TAG_BITS-1:0] list_t;

  typedef enum logic [21:0] {
    S_CLR    = 22'h000001,
    S_IDLE   = 22'h000002,
    S_WRAP   = 22'h000004,
    S_LOAD   = 22'h000008,
    S_DISP   = 22'h000010,
    S_SRCH   = 22'h000020,
    S_TDONE  = 22'h000040,
    S_TPUSH  = 22'h000080,
    S_IDONE  = 22'h000100,
    S_MB1    = 22'h000200,
    S_MB2    = 22'h000400,
    S_ADAPT  = 22'h000800,
    S_DIV    = 22'h001000,
    S_ADJ    = 22'h002000,
    S_VPREP  = 22'h004000,
    S_VSCAN  = 22'h008000,
    S_EVICT  = 22'h010000,
    S_FILL   = 22'h020000,
    S_FB1    = 22'h040000,
    S_FB2    = 22'h080000,
    S_PLACE  = 22'h100000,
    S_WRITE  = 22'h200000
  } state_t;

  state_t state, ret;

  logic [ROW_W-1:0] set_mem [NUM_SETS];
  logic [ROW_W-1:0] mem_q;
  logic [ROW_W-1:0] mem_d;
  logic [SW-1:0]    mem_a;
  logic             mem_we, mem_re;
  logic [SW-1:0]    clr_a;

  logic [1:0]          func_r;
  logic [5:0]          set_r;
  logic [2:0]          way_r;
  logic [TAG_BITS-1:0] tag_r;

  logic [WAYS-1:0][TAG_BITS-1:0] tags;
  logic [WAYS-1:0][1:0]          stat;
  list_t [3:0]                   lst;
  logic [3:0][LW-1:0]            len;
  logic [LW-1:0]                 p;

  logic [1:0]          srch_l;
  logic [TAG_BITS-1:0] srch_key;
  logic [LW-1:0]       srch_i;
  logic                srch_found;
  logic [WI-1:0]       srch_idx;

  logic          in_b1, in_b2, rl1, has_src, to_freq, div_up;
  logic [WI-1:0] victim, fb_way;
  logic          fb_hit;
  logic [LW-1:0] vi;
  logic [TAG_BITS-1:0] vt;

  logic                used_r, evv_r, placed_r;
  logic [TAG_BITS-1:0] evtag_r;

  logic          div_start, div_done;
  logic [LW-1:0] div_num, div_den, div_q;

  logic          way_ok;
  logic [WI-1:0] way_idx;
  logic          free_any;
  logic [WI-1:0] free_w;
  logic [LW-1:0] d_val, p_up, p_dn;
  logic [LW:0]   p_sum;
  logic          take_raw;

  function automatic list_t push_head(list_t e, logic [TAG_BITS-1:0] t);
    list_t r;
    r[0] = t;
    for (int j = 1; j < WAYS; j++) r[j] = e[j-1];
    return r;
  endfunction

  function automatic list_t remove_at(list_t e, logic [WI-1:0] idx);
    list_t r;
    for (int j = 0; j < WAYS; j++) begin
      if (j < WAYS-1 && WI'(j) >= idx) r[j] = e[j+1];
      else                             r[j] = e[j];
    end
    return r;
  endfunction

  function automatic logic [LW-1:0] inc_len(logic [LW-1:0] n);
    return (n >= LW'(WAYS)) ? LW'(WAYS) : n + 1'b1;
  endfunction

  function automatic logic [LW-1:0] dec_len(logic [LW-1:0] n);
    return (n != '0) ? n - 1'b1 : n;
  endfunction

  function automatic logic take_recent(logic [LW-1:0] t1n, logic [LW-1:0] pv, logic b2);
    return (t1n != '0) && ((t1n > pv) || (b2 && t1n == pv));
  endfunction

  arc_div #(.W(LW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  assign way_ok  = 32'(way_r) < WAYS;
  assign way_idx = WI'(way_r);

  always_comb begin
    free_any = 1'b0;
    free_w   = '0;
    for (int i = WAYS-1; i >= 0; i--) begin
      if (stat[i] == ST_INVALID) begin
        free_any = 1'b1;
        free_w   = WI'(i);
      end
    end
  end

  always_comb begin
    d_val = (div_q == '0) ? LW'(1) : div_q;
    p_sum = {1'b0, p} + {1'b0, d_val};
    p_up  = (p_sum > (LW+1)'(WAYS)) ? LW'(WAYS) : p_sum[LW-1:0];
    p_dn  = (p > d_val) ? p - d_val : '0;
  end

  assign take_raw = take_recent(len[L_T1], p, 1'b0);

  assign s_tready = (state == S_IDLE);
  assign mem_re   = (state == S_WRAP) && (32'(set_r) < NUM_SETS);
  assign mem_we   = (state == S_CLR) || ((state == S_WRAP) ? 1'b0 :
                    ((state == S_WRITE) && (!m_tvalid || m_tready)));
  assign mem_a    = (state == S_CLR) ? clr_a : SW'(set_r);
  assign mem_d    = (state == S_CLR) ? '0 : {p, len, lst, stat, tags};

  always_ff @(posedge clk) begin
    if (mem_we) set_mem[mem_a] <= mem_d;
    if (mem_re) mem_q <= set_mem[mem_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_a     <= '0;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= (state == S_ADAPT) && (in_b1 || in_b2);
      if (m_tvalid && m_tready && state != S_WRITE) m_tvalid <= 1'b0;
      unique case (state)
        S_CLR: begin
          if (32'(clr_a) == NUM_SETS-1) state <= S_IDLE;
          else                          clr_a <= clr_a + 1'b1;
        end
        S_IDLE: begin
          if (s_tvalid) begin
            func_r   <= s_tdata[1:0];
            set_r    <= s_tdata[7:2];
            way_r    <= s_tdata[10:8];
            tag_r    <= s_tdata[10+TAG_BITS:11];
            used_r   <= 1'b0;
            evv_r    <= 1'b0;
            evtag_r  <= '0;
            placed_r <= 1'b0;
            victim   <= '0;
            state    <= S_WRAP;
          end
        end
        S_WRAP: begin
          if (32'(set_r) >= NUM_SETS) set_r <= set_r - 6'(NUM_SETS);
          else                        state <= S_LOAD;
        end
        S_LOAD: begin
          {p, len, lst, stat, tags} <= mem_q;
          state <= S_DISP;
        end
        S_DISP: begin
          srch_i <= '0;
          unique case (func_r)
            FN_TOUCH: begin
              if (way_ok && stat[way_idx] != ST_INVALID) begin
                srch_l   <= (stat[way_idx] == ST_RECENT) ? L_T1 : L_T2;
                srch_key <= tags[way_idx];
                ret      <= S_TDONE;
                state    <= S_SRCH;
              end else begin
                state <= S_WRITE;
              end
            end
            FN_INVAL: begin
              if (way_ok && (stat[way_idx] == ST_RECENT || stat[way_idx] == ST_FREQ)) begin
                srch_l   <= (stat[way_idx] == ST_RECENT) ? L_T1 : L_T2;
                srch_key <= tags[way_idx];
                ret      <= S_IDONE;
                state    <= S_SRCH;
              end else begin
                if (way_ok) stat[way_idx] <= ST_INVALID;
                state <= S_WRITE;
              end
            end
            FN_MISS: begin
              if (free_any) begin
                victim <= free_w;
                used_r <= 1'b1;
                state  <= S_FILL;
              end else begin
                srch_l   <= L_B1;
                srch_key <= tag_r;
                ret      <= S_MB1;
                state    <= S_SRCH;
              end
            end
            default: state <= S_WRITE;
          endcase
        end
        S_SRCH: begin
          if (srch_i < len[srch_l]) begin
            if (lst[srch_l][srch_i[WI-1:0]] == srch_key) begin
              srch_found <= 1'b1;
              srch_idx   <= srch_i[WI-1:0];
              state      <= ret;
            end else begin
              srch_i <= srch_i + 1'b1;
            end
          end else begin
            srch_found <= 1'b0;
            state      <= ret;
          end
        end
        S_TDONE: begin
          if (srch_found) begin
            lst[srch_l] <= remove_at(lst[srch_l], srch_idx);
            len[srch_l] <= len[srch_l] - 1'b1;
          end
          state <= S_TPUSH;
        end
        S_TPUSH: begin
          lst[L_T2]     <= push_head(lst[L_T2], tags[way_idx]);
          len[L_T2]     <= inc_len(len[L_T2]);
          stat[way_idx] <= ST_FREQ;
          placed_r      <= 1'b1;
          state         <= S_WRITE;
        end
        S_IDONE: begin
          if (srch_found) begin
            lst[srch_l] <= remove_at(lst[srch_l], srch_idx);
            len[srch_l] <= len[srch_l] - 1'b1;
          end
          stat[way_idx] <= ST_INVALID;
          state         <= S_WRITE;
        end
        S_MB1: begin
          in_b1  <= srch_found;
          srch_l <= L_B2;
          srch_i <= '0;
          ret    <= S_MB2;
          state  <= S_SRCH;
        end
        S_MB2: begin
          in_b2 <= srch_found;
          state <= S_ADAPT;
        end
        S_ADAPT: begin
          if (in_b1) begin
            div_num   <= len[L_B2];
            div_den   <= len[L_B1];
            div_up    <= 1'b1;
            state     <= S_DIV;
          end else if (in_b2) begin
            div_num   <= len[L_B1];
            div_den   <= len[L_B2];
            div_up    <= 1'b0;
            state     <= S_DIV;
          end else if (32'(len[L_T1]) + 32'(len[L_B1]) >= WAYS) begin
            if (32'(len[L_T1]) < WAYS) begin
              len[L_B1] <= dec_len(len[L_B1]);
              rl1       <= take_raw;
            end else begin
              rl1 <= 1'b1;
            end
            state <= S_VPREP;
          end else begin
            if (32'(len[L_T1]) + 32'(len[L_T2]) + 32'(len[L_B1]) + 32'(len[L_B2])
                >= 2*WAYS) begin
              len[L_B2] <= dec_len(len[L_B2]);
            end
            rl1   <= take_raw;
            state <= S_VPREP;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_ADJ;
        end
        S_ADJ: begin
          if (div_up) begin
            p   <= p_up;
            rl1 <= take_recent(len[L_T1], p_up, in_b2);
          end else begin
            p   <= p_dn;
            rl1 <= take_recent(len[L_T1], p_dn, 1'b1);
          end
          state <= S_VPREP;
        end
        S_VPREP: begin
          logic          r;
          logic [1:0]    src;
          r = rl1 ? (len[L_T1] != '0) : (len[L_T2] == '0);
          src = r ? L_T1 : L_T2;
          rl1 <= r;
          victim <= '0;
          fb_hit <= 1'b0;
          fb_way <= '0;
          vi     <= '0;
          if (len[src] != '0) begin
            has_src <= 1'b1;
            vt      <= lst[src][WI'(len[src] - 1'b1)];
            state   <= S_VSCAN;
          end else begin
            has_src <= 1'b0;
            state   <= S_EVICT;
          end
        end
        S_VSCAN: begin
          if (vi == LW'(WAYS)) begin
            victim <= fb_way;
            state  <= S_EVICT;
          end else begin
            if (stat[vi[WI-1:0]] == (rl1 ? ST_RECENT : ST_FREQ)) begin
              if (tags[vi[WI-1:0]] == vt) begin
                victim <= vi[WI-1:0];
                state  <= S_EVICT;
              end else if (!fb_hit) begin
                fb_hit <= 1'b1;
                fb_way <= vi[WI-1:0];
              end
            end
            vi <= vi + 1'b1;
          end
        end
        S_EVICT: begin
          if (has_src) begin
            if (rl1) begin
              lst[L_B1] <= push_head(lst[L_B1], vt);
              len[L_B1] <= inc_len(len[L_B1]);
              len[L_T1] <= len[L_T1] - 1'b1;
            end else begin
              lst[L_B2] <= push_head(lst[L_B2], vt);
              len[L_B2] <= inc_len(len[L_B2]);
              len[L_T2] <= len[L_T2] - 1'b1;
            end
          end
          evv_r        <= 1'b1;
          evtag_r      <= tags[victim];
          stat[victim] <= ST_INVALID;
          state        <= S_FILL;
        end
        S_FILL: begin
          tags[victim] <= tag_r;
          srch_l       <= L_B1;
          srch_key     <= tag_r;
          srch_i       <= '0;
          ret          <= S_FB1;
          state        <= S_SRCH;
        end
        S_FB1: begin
          if (srch_found) begin
            lst[L_B1] <= remove_at(lst[L_B1], srch_idx);
            len[L_B1] <= len[L_B1] - 1'b1;
            to_freq   <= 1'b1;
            state     <= S_PLACE;
          end else begin
            srch_l <= L_B2;
            srch_i <= '0;
            ret    <= S_FB2;
            state  <= S_SRCH;
          end
        end
        S_FB2: begin
          if (srch_found) begin
            lst[L_B2] <= remove_at(lst[L_B2], srch_idx);
            len[L_B2] <= len[L_B2] - 1'b1;
          end
          to_freq <= srch_found;
          state   <= S_PLACE;
        end
        S_PLACE: begin
          if (to_freq) begin
            lst[L_T2]    <= push_head(lst[L_T2], tag_r);
            len[L_T2]    <= inc_len(len[L_T2]);
            stat[victim] <= ST_FREQ;
            placed_r     <= 1'b1;
          end else begin
            lst[L_T1]    <= push_head(lst[L_T1], tag_r);
            len[L_T1]    <= inc_len(len[L_T1]);
            stat[victim] <= ST_RECENT;
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({4'(p), placed_r, evtag_r, evv_r, used_r,
                                (func_r == FN_MISS) ? 3'(victim) : way_r});
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
